/* design/ifr_pkg.sv */
`timescale 1ns / 1ps

package ifr_pkg;

    // frame layout
    localparam int BUFFER_BYTES   = 128;
    localparam int HDR_LEN        = 6;
    localparam int VERSION_POS    = 6;
    localparam int TYPE_POS       = 7;
    localparam int LEN_POS        = 8;
    localparam int PAYLOAD_POS    = 9;
    localparam int FRAME_OVERHEAD = 10;
    localparam int POS_W          = 9;

    localparam logic [7:0] PROTO_VERSION = 8'h01;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // header characters
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_V = 8'h56;

    // payload buffer: one bank holds one frame in 64-bit words
    localparam int PAY_WORDS = (BUFFER_BYTES - FRAME_OVERHEAD + 8) / 8;
    localparam int WORD_AW   = (PAY_WORDS > 1) ? $clog2(PAY_WORDS) : 1;
    localparam int MEM_DEPTH = 2 ** (WORD_AW + 1);

    // job queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input kind codes
    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } in_kind_t;

    // result kind codes
    typedef enum logic [1:0] {
        RK_HEADER = 2'd0,
        RK_WORD   = 2'd1,
        RK_REJECT = 2'd2
    } rkind_t;

    // completed frame handed from front to back
    typedef struct packed {
        logic       accepted;
        logic [7:0] ptype;
        logic [7:0] plen;
        logic       bank;
    } job_t;

    // payload byte write into the buffer
    typedef struct packed {
        logic               en;
        logic               bank;
        logic [WORD_AW-1:0] addr;
        logic [2:0]         lane;
        logic [7:0]         data;
    } wr_t;

    // one result item
    typedef struct packed {
        rkind_t      kind;
        logic [7:0]  ptype;
        logic [7:0]  plen;
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } res_t;

    function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = CH_I;
            3'd1:    b = CH_M;
            3'd2:    b = CH_P;
            3'd3:    b = CH_R;
            3'd4:    b = CH_O;
            3'd5:    b = CH_V;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* design/ifr_front.sv */
`timescale 1ns / 1ps

module ifr_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,
    input  logic                in_kind,
    input  logic [7:0]          in_byte,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    output logic                push,
    output ifr_pkg::job_t       job,
    output ifr_pkg::wr_t        wr
);

    logic [ifr_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]                sum_reg, sum_next;
    logic [15:0]               idle_reg, idle_next;
    logic [15:0]               timeout_reg;
    logic [7:0]                ver_reg, ver_next;
    logic [7:0]                type_reg, type_next;
    logic [7:0]                len_reg, len_next;
    logic                      bank_reg, bank_next;

    logic [ifr_pkg::POS_W-1:0] eff_pos, pos_inc, total, pay_idx;
    logic [7:0]                eff_sum, cur_len;
    logic                      stale;

    // parse one item against the frame position
    always_comb begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        idle_next = idle_reg;
        ver_next  = ver_reg;
        type_next = type_reg;
        len_next  = len_reg;
        bank_next = bank_reg;
        push      = 1'b0;
        job       = '0;
        wr        = '0;

        stale   = (pos_reg != '0) && (idle_reg > timeout_reg);
        eff_pos = stale ? '0 : pos_reg;
        eff_sum = stale ? '0 : sum_reg;
        cur_len = (eff_pos == ifr_pkg::POS_W'(ifr_pkg::LEN_POS)) ? in_byte : len_reg;
        total   = ifr_pkg::POS_W'(ifr_pkg::FRAME_OVERHEAD) + {1'b0, cur_len};
        pos_inc = eff_pos + 1'b1;
        pay_idx = eff_pos - ifr_pkg::POS_W'(ifr_pkg::PAYLOAD_POS);

        if (take) begin
            if (in_kind == ifr_pkg::KIND_TICK) begin
                // idle counter saturates
                if (idle_reg != '1) begin
                    idle_next = idle_reg + 16'd1;
                end
            end else begin
                idle_next = '0;
                if (eff_pos < ifr_pkg::POS_W'(ifr_pkg::HDR_LEN)) begin
                    // header hunt, restart on the first header character
                    if (in_byte == ifr_pkg::hdr_byte(eff_pos[2:0])) begin
                        pos_next = pos_inc;
                        sum_next = eff_sum + in_byte;
                    end else if (in_byte == ifr_pkg::CH_I) begin
                        pos_next = ifr_pkg::POS_W'(1);
                        sum_next = in_byte;
                    end else begin
                        pos_next = '0;
                        sum_next = '0;
                    end
                end else if (eff_pos >= ifr_pkg::POS_W'(ifr_pkg::BUFFER_BYTES)) begin
                    pos_next = '0;
                    sum_next = '0;
                end else begin
                    // capture fixed fields
                    if (eff_pos == ifr_pkg::POS_W'(ifr_pkg::VERSION_POS)) begin
                        ver_next = in_byte;
                    end
                    if (eff_pos == ifr_pkg::POS_W'(ifr_pkg::TYPE_POS)) begin
                        type_next = in_byte;
                    end
                    if (eff_pos == ifr_pkg::POS_W'(ifr_pkg::LEN_POS)) begin
                        len_next = in_byte;
                    end
                    // payload bytes go to the buffer bank of this frame
                    if (eff_pos >= ifr_pkg::POS_W'(ifr_pkg::PAYLOAD_POS)) begin
                        wr.en   = 1'b1;
                        wr.bank = bank_reg;
                        wr.addr = pay_idx[ifr_pkg::WORD_AW+2:3];
                        wr.lane = pay_idx[2:0];
                        wr.data = in_byte;
                    end
                    if (pos_inc < ifr_pkg::POS_W'(ifr_pkg::PAYLOAD_POS)) begin
                        pos_next = pos_inc;
                        sum_next = eff_sum + in_byte;
                    end else if (total > ifr_pkg::POS_W'(ifr_pkg::BUFFER_BYTES)) begin
                        pos_next = '0;
                        sum_next = '0;
                    end else if (pos_inc < total) begin
                        pos_next = pos_inc;
                        sum_next = eff_sum + in_byte;
                    end else begin
                        // checksum byte closes the frame
                        push         = 1'b1;
                        job.accepted = (eff_sum == in_byte) &&
                                       (ver_reg == ifr_pkg::PROTO_VERSION);
                        job.ptype    = type_reg;
                        job.plen     = cur_len;
                        job.bank     = bank_reg;
                        bank_next    = ~bank_reg;
                        pos_next     = '0;
                        sum_next     = '0;
                    end
                end
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            sum_reg     <= '0;
            idle_reg    <= '0;
            timeout_reg <= ifr_pkg::TIMEOUT_RESET;
            bank_reg    <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            idle_reg <= idle_next;
            bank_reg <= bank_next;
            if (cfg_we) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    // frame fields
    always_ff @(posedge aclk) begin
        ver_reg  <= ver_next;
        type_reg <= type_next;
        len_reg  <= len_next;
    end

endmodule

/* design/ifr_job_queue.sv */
`timescale 1ns / 1ps

module ifr_job_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  ifr_pkg::job_t              push_job,
    input  logic                       pop,
    output ifr_pkg::job_t              head,
    output logic                       empty,
    output logic                       full,
    output logic [ifr_pkg::QCNT_W-1:0] count
);

    ifr_pkg::job_t                  entry_reg [ifr_pkg::QUEUE_DEPTH];
    logic                           wr_ptr_reg, rd_ptr_reg;
    logic [ifr_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == ifr_pkg::QCNT_W'(ifr_pkg::QUEUE_DEPTH));
    assign count = count_reg;

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* design/ifr_back.sv */
`timescale 1ns / 1ps

module ifr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  ifr_pkg::wr_t        wr,
    input  ifr_pkg::job_t       head,
    input  logic                q_empty,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_ready,
    output ifr_pkg::res_t       res
);

    typedef enum logic [2:0] {
        BK_IDLE  = 3'b001,
        BK_FETCH = 3'b010,
        BK_LOAD  = 3'b100
    } bk_state_t;

    bk_state_t                   state_reg, state_next;
    logic [ifr_pkg::WORD_AW-1:0] idx_reg, idx_next;
    logic [7:0]                  remain_reg, remain_next;
    logic                        valid_reg, valid_next;
    ifr_pkg::res_t               res_reg, res_next;
    logic                        res_load;

    logic [63:0] mem [ifr_pkg::MEM_DEPTH];
    logic [63:0] rd_data_reg;
    logic [63:0] masked;
    logic [3:0]  nb;
    logic        out_free;

    // payload buffer, byte-lane writes from the front
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[{wr.bank, wr.addr}][{wr.lane, 3'b000} +: 8] <= wr.data;
        end
        rd_data_reg <= mem[{head.bank, idx_reg}];
    end

    assign out_free = !valid_reg || res_ready;
    assign nb       = (remain_reg > 8'd8) ? 4'd8 : remain_reg[3:0];

    // keep only the valid lanes of the word
    always_comb begin
        masked = '0;
        for (int j = 0; j < 8; j++) begin
            if (4'(j) < nb) begin
                masked[j*8 +: 8] = rd_data_reg[j*8 +: 8];
            end
        end
    end

    // result sequencer
    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        remain_next = remain_reg;
        res_next    = res_reg;
        res_load    = 1'b0;
        pop         = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty && out_free) begin
                    res_load      = 1'b1;
                    res_next      = '0;
                    if (!head.accepted) begin
                        res_next.kind = ifr_pkg::RK_REJECT;
                        res_next.last = 1'b1;
                        pop           = 1'b1;
                    end else begin
                        res_next.kind  = ifr_pkg::RK_HEADER;
                        res_next.ptype = head.ptype;
                        res_next.plen  = head.plen;
                        res_next.last  = (head.plen == 8'd0);
                        if (head.plen == 8'd0) begin
                            pop = 1'b1;
                        end else begin
                            idx_next    = '0;
                            remain_next = head.plen;
                            state_next  = BK_FETCH;
                        end
                    end
                end
            end
            BK_FETCH: begin
                state_next = BK_LOAD;
            end
            BK_LOAD: begin
                if (out_free) begin
                    res_load        = 1'b1;
                    res_next        = '0;
                    res_next.kind   = ifr_pkg::RK_WORD;
                    res_next.word   = masked;
                    res_next.nbytes = nb;
                    res_next.last   = (remain_reg <= 8'd8);
                    if (remain_reg <= 8'd8) begin
                        pop        = 1'b1;
                        state_next = BK_IDLE;
                    end else begin
                        idx_next    = idx_reg + 1'b1;
                        remain_next = remain_reg - 8'd8;
                        state_next  = BK_FETCH;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb begin
        valid_next = valid_reg;
        if (res_load) begin
            valid_next = 1'b1;
        end else if (res_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        remain_reg <= remain_next;
        res_reg    <= res_next;
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

/* design/improv_frame_receiver.sv */
`timescale 1ns / 1ps

// channel  | direction | transfer carries
// ---------+-----------+----------------------------------------------------
// s_axis   | in        | tuser: kind; tdata: byte_value
// m_axis   | out       | tuser: result_kind; tlast: last; tdata: packet_type,
//          |           |   payload_length, data_word, word_bytes
// cfg      | in        | cfg_data: resync_timeout_ms
//
// The front parses one input transfer per cycle and writes payload bytes into
// one of two buffer banks. A finished frame becomes a job in a two-entry queue.
// The back loads a header or reject result straight into the output register;
// each payload word passes the buffer read register, then the output register.
// s_tready drops while two finished frames are waiting in the queue.
// Reset is synchronous and clears control state; the buffer needs no clearing.

module improv_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [7:0] packet_type, [15:8] payload_length,
                                   // [79:16] data_word, [83:80] word_bytes, rest 0
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic                       take;
    logic                       push, pop, q_empty, q_full;
    logic [ifr_pkg::QCNT_W-1:0] q_count;
    ifr_pkg::job_t              push_job, head;
    ifr_pkg::wr_t               wr;
    ifr_pkg::res_t              res;

    assign s_tready  = !q_full;
    assign take      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    ifr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .in_kind  (s_tuser[0]),
        .in_byte  (s_tdata),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .push     (push),
        .job      (push_job),
        .wr       (wr)
    );

    ifr_job_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full),
        .count    (q_count)
    );

    ifr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // result packing
    assign m_tuser = res.kind;
    assign m_tlast = res.last;
    assign m_tdata = {4'd0, res.nbytes, res.word, res.plen, res.ptype};

    // a rejected frame is always a single result with no data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ifr_pkg::RK_REJECT) |-> (m_tlast && m_tdata[83:80] == 4'd0))
        else $error("reject result not final or carries data");

    // payload words carry one to eight bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ifr_pkg::RK_WORD) |->
        (m_tdata[83:80] != 4'd0 && m_tdata[83:80] <= 4'd8))
        else $error("payload word byte count out of range");

    // an accepted frame with no payload ends at its header
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ifr_pkg::RK_HEADER && m_tdata[15:8] == 8'd0) |-> m_tlast)
        else $error("empty frame header not marked last");

    // input stalls only with the job queue full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (q_count == ifr_pkg::QCNT_W'(ifr_pkg::QUEUE_DEPTH) && !q_empty))
        else $error("input stalled with room in the job queue");

endmodule
